/* rtl/ohash_pkg.sv */
// Shared types, codes and constants for the open-addressed hash table.
package ohash_pkg;

    localparam int TABLE_SIZE_DEF = 128;
    localparam int KEY_BITS_DEF   = 40;
    localparam int KEY_W          = 40;
    localparam int STATUS_W       = 2;
    localparam int SLOT_W         = 7;
    localparam int COUNT_W        = 8;
    localparam int WIDE_W         = 64;
    localparam int MOD_DIGIT      = 4;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_INVALID   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SLOT_EMPTY   = 2'd0,
        SLOT_USED    = 2'd1,
        SLOT_DELETED = 2'd2
    } t_slot;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [COUNT_W-1:0]  entry_count;
    } t_out_item;

    typedef struct packed {
        logic    latch;
        logic    load_pos;
        logic    advance;
        logic    wr_insert;
        logic    wr_delete;
        logic    clr_wr;
        logic    out_load;
        t_status res;
    } t_cmd;

    typedef struct packed {
        logic key_zero;
        logic op_delete;
        logic cnt_full;
        logic mod_done;
        logic slot_empty;
        logic slot_used;
        logic slot_deleted;
        logic key_match;
        logic last_step;
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

/* rtl/ohash_mod.sv */
// Reduction of a key modulo the table size: a bit slice when the size is a power of two, else a serial remainder unit.
module ohash_mod #(
    parameter int TABLE_SIZE = ohash_pkg::TABLE_SIZE_DEF,
    parameter int KEY_BITS   = ohash_pkg::KEY_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [KEY_BITS-1:0]           i_value,
    output logic                          o_done,
    output logic [$clog2(TABLE_SIZE)-1:0] o_rem
);
    localparam int IDXW  = $clog2(TABLE_SIZE);
    localparam int DIGIT = ohash_pkg::MOD_DIGIT;
    localparam int KPAD  = ((KEY_BITS + DIGIT - 1) / DIGIT) * DIGIT;
    localparam int STEPS = KPAD / DIGIT;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int EXTW  = (KPAD > IDXW) ? KPAD : IDXW;
    localparam bit POW2  = ((1 << IDXW) == TABLE_SIZE);

    logic [IDXW-1:0] r_rem;
    logic            r_done;

    assign o_done = r_done;
    assign o_rem  = r_rem;

    if (POW2) begin : g_pow2
        logic [EXTW-1:0] value_ext;

        assign value_ext = EXTW'(i_value);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else if (i_start) begin
                r_done <= 1'b1;
            end
            if (i_start) begin
                r_rem <= value_ext[IDXW-1:0];
            end
        end
    end else begin : g_serial
        logic [KPAD-1:0] r_val;
        logic [CW-1:0]   r_cnt;
        logic            r_busy;
        logic [IDXW-1:0] n_rem;

        always_comb begin
            logic [IDXW:0] t;
            t     = '0;
            n_rem = r_rem;
            for (int j = 0; j < DIGIT; j++) begin
                t = {n_rem, r_val[KPAD-1-j]};
                if (t >= (IDXW+1)'(TABLE_SIZE)) begin
                    t = t - (IDXW+1)'(TABLE_SIZE);
                end
                n_rem = t[IDXW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_busy <= 1'b0;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= CW'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
            if (i_start) begin
                r_val <= KPAD'(i_value);
                r_rem <= '0;
            end else if (r_busy) begin
                r_val <= r_val << DIGIT;
                r_rem <= n_rem;
            end
        end
    end

endmodule

/* rtl/ohash_ctrl.sv */
// Controller state machine that sequences each hash table operation.
module ohash_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  ohash_pkg::t_sts   i_sts,
    output logic              o_busy,
    output ohash_pkg::t_cmd   o_cmd
);
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_DONE
    } t_state;

    t_state             r_state;
    t_state             n_state;
    ohash_pkg::t_status r_res;
    ohash_pkg::t_status n_res;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state        = r_state;
        n_res          = r_res;
        o_cmd          = '0;
        o_cmd.res      = r_res;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_MOD;
                end
            end
            S_MOD: begin
                if (i_sts.key_zero) begin
                    n_res   = ohash_pkg::ST_INVALID;
                    n_state = S_DONE;
                end else if (!i_sts.op_delete && i_sts.cnt_full) begin
                    n_res   = ohash_pkg::ST_FULL;
                    n_state = S_DONE;
                end else if (i_sts.mod_done) begin
                    o_cmd.load_pos = 1'b1;
                    n_state        = S_PROBE_RD;
                end
            end
            S_PROBE_RD: begin
                n_state = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                if (!i_sts.op_delete) begin
                    if (i_sts.slot_empty || i_sts.slot_deleted) begin
                        o_cmd.wr_insert = 1'b1;
                        n_res           = ohash_pkg::ST_OK;
                        n_state         = S_DONE;
                    end else if (i_sts.last_step) begin
                        n_res   = ohash_pkg::ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_PROBE_RD;
                    end
                end else begin
                    if (i_sts.slot_empty) begin
                        n_res   = ohash_pkg::ST_NOT_FOUND;
                        n_state = S_DONE;
                    end else if (i_sts.slot_used && i_sts.key_match) begin
                        o_cmd.wr_delete = 1'b1;
                        n_res           = ohash_pkg::ST_OK;
                        n_state         = S_DONE;
                    end else if (i_sts.last_step) begin
                        n_res   = ohash_pkg::ST_NOT_FOUND;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_PROBE_RD;
                    end
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_res   <= ohash_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

endmodule

/* rtl/ohash_dp.sv */
// Datapath: slot memory, probe position, entry count and result register.
module ohash_dp #(
    parameter int TABLE_SIZE = ohash_pkg::TABLE_SIZE_DEF,
    parameter int KEY_BITS   = ohash_pkg::KEY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ohash_pkg::t_in_item  i_in_item,
    input  ohash_pkg::t_cmd      i_cmd,
    output ohash_pkg::t_sts      o_sts,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output ohash_pkg::t_out_item o_out_item
);
    localparam int IDXW = $clog2(TABLE_SIZE);
    localparam int SW   = $clog2(TABLE_SIZE + 1);
    localparam int MW   = KEY_BITS + 2;
    localparam int WW   = ohash_pkg::WIDE_W;

    logic [MW-1:0]       r_mem [TABLE_SIZE];
    logic [MW-1:0]       r_rd_data;
    logic                r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [IDXW-1:0]     r_pos;
    logic [SW-1:0]       r_step;
    logic [SW-1:0]       r_count;
    logic [IDXW-1:0]     r_clr_addr;
    logic                r_out_valid;
    ohash_pkg::t_out_item r_out;

    logic [WW-1:0]       key_wide;
    logic [KEY_BITS-1:0] key_in;
    logic                mod_done;
    logic [IDXW-1:0]     mod_rem;
    logic [IDXW+1:0]     psum;
    logic [IDXW-1:0]     pos_next;
    logic                wr_en;
    logic [IDXW-1:0]     wr_addr;
    logic [MW-1:0]       wr_data;
    logic [1:0]          rd_slot;
    logic [31:0]         pos_ext;
    logic [31:0]         cnt_ext;
    logic                out_free;

    assign key_wide = WW'(i_in_item.key);
    assign key_in   = key_wide[KEY_BITS-1:0];

    ohash_mod #(
        .TABLE_SIZE(TABLE_SIZE),
        .KEY_BITS  (KEY_BITS)
    ) u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.latch),
        .i_value(key_in),
        .o_done (mod_done),
        .o_rem  (mod_rem)
    );

    always_comb begin
        psum = (IDXW+2)'(r_pos) + (IDXW+2)'(r_step);
        if (psum >= (IDXW+2)'(TABLE_SIZE)) begin
            psum = psum - (IDXW+2)'(TABLE_SIZE);
        end
        pos_next = psum[IDXW-1:0];
    end

    assign wr_en   = i_cmd.clr_wr | i_cmd.wr_insert | i_cmd.wr_delete;
    assign wr_addr = i_cmd.clr_wr ? r_clr_addr : r_pos;

    always_comb begin
        if (i_cmd.clr_wr) begin
            wr_data = {ohash_pkg::SLOT_EMPTY, {KEY_BITS{1'b0}}};
        end else if (i_cmd.wr_insert) begin
            wr_data = {ohash_pkg::SLOT_USED, r_key};
        end else begin
            wr_data = {ohash_pkg::SLOT_DELETED, r_key};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_pos];
    end

    assign rd_slot  = r_rd_data[MW-1 -: 2];
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_sts.key_zero     = (r_key == '0);
    assign o_sts.op_delete    = (r_op == ohash_pkg::OP_DELETE);
    assign o_sts.cnt_full     = (r_count >= SW'(TABLE_SIZE));
    assign o_sts.mod_done     = mod_done;
    assign o_sts.slot_empty   = (rd_slot == ohash_pkg::SLOT_EMPTY);
    assign o_sts.slot_used    = (rd_slot == ohash_pkg::SLOT_USED);
    assign o_sts.slot_deleted = (rd_slot == ohash_pkg::SLOT_DELETED);
    assign o_sts.key_match    = (r_rd_data[KEY_BITS-1:0] == r_key);
    assign o_sts.last_step    = (r_step == SW'(TABLE_SIZE));
    assign o_sts.clr_last     = (r_clr_addr == IDXW'(TABLE_SIZE - 1));
    assign o_sts.out_free     = out_free;

    assign pos_ext = 32'(r_pos);
    assign cnt_ext = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.wr_insert) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.wr_delete && r_count != '0) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.load_pos) begin
                r_pos <= mod_rem;
            end else if (i_cmd.advance) begin
                r_pos <= pos_next;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.latch) begin
            r_op  <= i_in_item.opcode;
            r_key <= key_in;
        end
        if (i_cmd.load_pos) begin
            r_step <= SW'(1);
        end else if (i_cmd.advance) begin
            r_step <= r_step + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out.status      <= i_cmd.res;
            r_out.slot_index  <= (i_cmd.res == ohash_pkg::ST_OK) ?
                                 pos_ext[ohash_pkg::SLOT_W-1:0] : '0;
            r_out.entry_count <= cnt_ext[ohash_pkg::COUNT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SW'(TABLE_SIZE))
        else $error("entry count above table size");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < IDXW'(TABLE_SIZE - 1) || r_pos == IDXW'(TABLE_SIZE - 1))
        else $error("probe position out of range");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clr_wr, i_cmd.wr_insert, i_cmd.wr_delete}))
        else $error("conflicting slot writes");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result loaded over a stalled item");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.wr_insert && !i_cmd.wr_delete |=> $stable(r_count))
        else $error("entry count changed without a slot write");
`endif

endmodule

/* rtl/open_addressing_hash_table.sv */
// Top level of the open-addressed hash table with triangular probing.
//
// Usage: after reset the block sweeps its slot memory, marking every slot
// empty, and holds o_in_stall high until the sweep ends. After that it takes
// one item (insert or delete of a key) at a time and returns one result item
// for each. An item is latched, then waits for its home slot: a bit slice of
// the key when TABLE_SIZE is a power of two, else the output of a
// 4-bit-per-cycle remainder unit. Each probed slot then passes a read state
// and a check state, since the slot memory has a registered read; the result
// is then loaded into the result register, which waits while an earlier
// result still sits in it under o_out_valid with i_out_stall high. An item
// with a zero key, or an insert into a full table, skips the probing. The
// next item is taken as soon as the result sits in the output register, even
// while the output side stalls.
module open_addressing_hash_table #(
    parameter int TABLE_SIZE = ohash_pkg::TABLE_SIZE_DEF,
    parameter int KEY_BITS   = ohash_pkg::KEY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ohash_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ohash_pkg::t_out_item o_out_item
);
    ohash_pkg::t_cmd cmd;
    ohash_pkg::t_sts sts;
    logic            busy;

    ohash_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_sts     (sts),
        .o_busy    (busy),
        .o_cmd     (cmd)
    );

    ohash_dp #(
        .TABLE_SIZE(TABLE_SIZE),
        .KEY_BITS  (KEY_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item)
    );

    assign o_in_stall = busy;

endmodule

/* verif/ohash_scoreboard.sv */
`timescale 1ns / 1ps
// Scoreboard for the hash table: mirrors its slot store and checks every result item.
module ohash_scoreboard (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  ohash_pkg::t_in_item  i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  ohash_pkg::t_out_item i_out_item,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_ok_count,
    output int                   o_full_count,
    output int                   o_miss_count,
    output int                   o_zero_count,
    output int                   o_peak_fill
);
    import ohash_pkg::*;

    localparam int TABLE_SIZE = TABLE_SIZE_DEF;
    localparam int KEY_BITS   = KEY_BITS_DEF;
    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

    t_slot            slot_state [TABLE_SIZE];
    logic [KEY_W-1:0] slot_key   [TABLE_SIZE];
    int               occupancy;
    int               peak_fill;
    t_out_item        expected_results [$];
    int               fail_total;
    int               checked;
    int               status_seen [4];

    assign o_fail_count = fail_total;
    assign o_pending    = expected_results.size();
    assign o_checked    = checked;
    assign o_ok_count   = status_seen[ST_OK];
    assign o_full_count = status_seen[ST_FULL];
    assign o_miss_count = status_seen[ST_NOT_FOUND];
    assign o_zero_count = status_seen[ST_INVALID];
    assign o_peak_fill  = peak_fill;

    initial begin
        fail_total = 0;
        checked    = 0;
        peak_fill  = 0;
        occupancy  = 0;
        for (int i = 0; i < 4; i++) begin
            status_seen[i] = 0;
        end
    end

    function automatic t_out_item table_op_result(input t_in_item it);
        t_out_item        r;
        logic [KEY_W-1:0] k;
        int               pos;
        r = '0;
        k = it.key & KEY_MASK;
        if (k == '0) begin
            r.status      = ST_INVALID;
            r.entry_count = COUNT_W'(occupancy);
            return r;
        end
        pos      = int'(k % KEY_W'(TABLE_SIZE));
        r.status = (it.opcode == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
        if (it.opcode == OP_INSERT && occupancy < TABLE_SIZE) begin
            for (int step = 1; step <= TABLE_SIZE; step++) begin
                if (slot_state[pos] != SLOT_USED) begin
                    slot_state[pos] = SLOT_USED;
                    slot_key[pos]   = k;
                    occupancy++;
                    r.status     = ST_OK;
                    r.slot_index = SLOT_W'(pos);
                    break;
                end
                pos = (pos + step) % TABLE_SIZE;
            end
        end else if (it.opcode == OP_DELETE) begin
            for (int step = 1; step <= TABLE_SIZE; step++) begin
                if (slot_state[pos] == SLOT_EMPTY) begin
                    break;
                end
                if (slot_state[pos] == SLOT_USED && slot_key[pos] == k) begin
                    slot_state[pos] = SLOT_DELETED;
                    if (occupancy > 0) begin
                        occupancy--;
                    end
                    r.status     = ST_OK;
                    r.slot_index = SLOT_W'(pos);
                    break;
                end
                pos = (pos + step) % TABLE_SIZE;
            end
        end
        if (occupancy > peak_fill) begin
            peak_fill = occupancy;
        end
        r.entry_count = COUNT_W'(occupancy);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("%0t: result %0d, %s: got %0d, expected %0d",
                 $time, checked, what, got_v, want_v);
        fail_total++;
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing outstanding", int'(got.status), 0);
            return;
        end
        want = expected_results.pop_front();
        checked++;
        status_seen[want.status]++;
        if (got.status != want.status) begin
            report_mismatch("status", int'(got.status), int'(want.status));
        end
        if (got.slot_index != want.slot_index) begin
            report_mismatch("slot_index", int'(got.slot_index), int'(want.slot_index));
        end
        if (got.entry_count != want.entry_count) begin
            report_mismatch("entry_count", int'(got.entry_count), int'(want.entry_count));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
                slot_state[i] = SLOT_EMPTY;
                slot_key[i]   = '0;
            end
            occupancy = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out_item);
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(table_op_result(i_in_item));
            end
        end
    end

endmodule

/* verif/open_addressing_hash_table_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the hash table: clock, reset, item stimulus, watchdog and verdict.
module open_addressing_hash_table_tb;
    import ohash_pkg::*;

    localparam int TABLE_SIZE     = TABLE_SIZE_DEF;
    localparam int PHASE_ITEMS    = 427;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    int fail_count;
    int pending;
    int checked;
    int ok_count;
    int full_count;
    int miss_count;
    int zero_count;
    int peak_fill;

    int               send_idle     = 21;
    int               recv_idle     = 59;
    int               items_sent    = 0;
    int               hold_requests = 0;
    int               holds_served  = 0;
    int               hold_left     = 0;
    int               quiet_cycles  = 0;
    logic [KEY_W-1:0] live_keys [$];

    open_addressing_hash_table uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    ohash_scoreboard u_scoreboard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_item  (o_out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_ok_count  (ok_count),
        .o_full_count(full_count),
        .o_miss_count(miss_count),
        .o_zero_count(zero_count),
        .o_peak_fill (peak_fill)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_requests != holds_served) begin
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("open_addressing_hash_table_tb: FAIL");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] rand_key();
        logic [KEY_W-1:0] k;
        k = {8'($urandom), 32'($urandom)};
        if ($urandom_range(1) == 1) begin
            k[SLOT_W-1:0] = {3'($urandom_range(7)), 4'b1001};
        end
        return k;
    endfunction

    task automatic send_item(input t_op op, input logic [KEY_W-1:0] key);
        t_in_item it;
        it.opcode = op;
        it.key    = key;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic insert_key(input logic [KEY_W-1:0] key);
        send_item(OP_INSERT, key);
        if (key != '0 && live_keys.size() < TABLE_SIZE) begin
            live_keys.push_back(key);
        end
    endtask

    task automatic delete_key(input logic [KEY_W-1:0] key);
        send_item(OP_DELETE, key);
        for (int i = 0; i < live_keys.size(); i++) begin
            if (key != '0 && live_keys[i] == key) begin
                live_keys.delete(i);
                break;
            end
        end
    endtask

    task automatic run_phase(input int n_items);
        int               goal;
        int               linger;
        int               roll;
        bit               rising;
        bit               grow;
        logic [KEY_W-1:0] key;
        goal   = TABLE_SIZE;
        rising = 1'b1;
        linger = 0;
        repeat (n_items) begin
            if (linger != 0) begin
                linger--;
            end else if (rising ? live_keys.size() >= goal : live_keys.size() <= goal) begin
                if (live_keys.size() >= TABLE_SIZE) begin
                    linger = 8;
                end
                case ($urandom_range(2))
                    0: goal = TABLE_SIZE;
                    1: goal = $urandom_range(40);
                    default: goal = $urandom_range(110, 40);
                endcase
                rising = goal > live_keys.size();
            end
            if (linger != 0) begin
                grow = $urandom_range(1) == 1;
            end else begin
                grow = $urandom_range(99) < (rising ? 80 : 20);
            end
            roll = $urandom_range(99);
            if (roll < 3) begin
                key = '0;
            end else if (live_keys.size() != 0 && linger == 0
                         && (grow ? roll < 15 : roll < 80)) begin
                key = live_keys[$urandom_range(live_keys.size() - 1)];
            end else begin
                key = rand_key();
            end
            if (grow) begin
                insert_key(key);
            end else begin
                delete_key(key);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        delete_key(40'd5);
        insert_key('0);
        delete_key('0);
        insert_key(KEY_MAX);
        insert_key(40'd1);
        insert_key(40'd129);
        insert_key(40'd257);
        insert_key(40'd129);
        delete_key(40'd129);
        delete_key(40'd129);
        delete_key(40'd129);
        insert_key(40'd385);
        delete_key(40'd257);
        insert_key(40'h80_0000_0000);
        insert_key(40'hAA_AAAA_AAAA);
        insert_key(40'h55_5555_5555);
        delete_key(KEY_MAX);
        delete_key(KEY_MAX);
        delete_key(40'h55_5555_5555);
        delete_key(40'd1);
        delete_key(40'd385);

        run_phase(PHASE_ITEMS / 2);
        hold_requests++;
        run_phase(PHASE_ITEMS - PHASE_ITEMS / 2);

        send_idle = 59;
        recv_idle = 21;
        run_phase(PHASE_ITEMS);

        send_idle = 0;
        recv_idle = 0;
        run_phase(PHASE_ITEMS / 3);
        hold_requests++;
        run_phase(PHASE_ITEMS - PHASE_ITEMS / 3);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d items, checked %0d results: %0d ok, %0d full, %0d not found,",
                 items_sent, checked, ok_count, full_count, miss_count);
        $display("%0d zero keys; occupancy peaked at %0d of %0d slots, %0d output holds.",
                 zero_count, peak_fill, TABLE_SIZE, holds_served);
        if (fail_count == 0 && pending == 0) begin
            $display("open_addressing_hash_table_tb: PASS");
        end else begin
            $display("open_addressing_hash_table_tb: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/ohash_pkg.sv
rtl/ohash_mod.sv
rtl/ohash_ctrl.sv
rtl/ohash_dp.sv
rtl/open_addressing_hash_table.sv
verif/ohash_scoreboard.sv
verif/open_addressing_hash_table_tb.sv
